FILE: design/se3e_pkg.sv
// Shared types and constants for the SE(3) exponential map pipeline.
// Depends on nothing; every other design file but se3e_smul refers to it by scoped name.
package se3e_pkg;

	localparam int FRAC_W       = 50;
	localparam int SERIES_TERMS = 20;
	localparam int LANES        = 3;
	localparam int DEN_W        = 11;
	localparam int CDIV_LAT     = 4;
	localparam int STEP_LAT     = CDIV_LAT + 3;
	localparam int SER_LAT      = SERIES_TERMS * STEP_LAT + CDIV_LAT + 1;
	localparam int R_SH         = FRAC_W - 30;
	localparam int V_SH         = 20;
	localparam int W_SH         = 29;
	localparam int W2_SH        = 58;
	localparam int VV_SH        = 30;

	localparam logic [63:0] ONE       = 64'd1 << FRAC_W;
	localparam logic [63:0] RECIP_NUM = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] R_HALF    = 64'd1 << (R_SH - 1);
	localparam logic [63:0] V_HALF    = 64'd1 << (V_SH - 1);
	localparam logic [63:0] R_LIMIT   = 64'd1 << 30;
	localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

	typedef struct packed {
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
	} twist_t;

	typedef struct packed {
		logic signed [31:0] m_00;
		logic signed [31:0] m_01;
		logic signed [31:0] m_02;
		logic signed [31:0] m_10;
		logic signed [31:0] m_11;
		logic signed [31:0] m_12;
		logic signed [31:0] m_20;
		logic signed [31:0] m_21;
		logic signed [31:0] m_22;
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic signed [31:0] move_z;
	} pose_t;

	typedef struct packed {
		logic [2:0][31:0] v;
		logic [2:0][31:0] w;
	} side_t;

endpackage

FILE: design/se3e_smul.sv
// Signed 64x64 multiply, scaled right and truncated toward zero, four stages.
// Depends on nothing beyond plain logic.
module se3e_smul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] a_i,
	input  logic signed [63:0] b_i,
	input  logic [6:0]         sh_i,
	output logic signed [63:0] p_o
);

	logic [63:0] am_s1, bm_s1;
	logic        neg_s1;
	logic [63:0] pp00_s2, pp01_s2, pp10_s2, pp11_s2;
	logic        neg_s2;
	logic [62:0] mag_s3;
	logic        neg_s3;
	logic signed [63:0] p_s4;
	logic [127:0] full_c, shr_c;

	always_comb begin
		full_c = {64'd0, pp00_s2} + {32'd0, pp01_s2, 32'd0} + {32'd0, pp10_s2, 32'd0}
			+ {pp11_s2, 64'd0};
		shr_c  = full_c >> sh_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
			bm_s1   <= b_i[63] ? 64'(-b_i) : 64'(b_i);
			neg_s1  <= a_i[63] ^ b_i[63];
			pp00_s2 <= am_s1[31:0] * bm_s1[31:0];
			pp01_s2 <= am_s1[31:0] * bm_s1[63:32];
			pp10_s2 <= am_s1[63:32] * bm_s1[31:0];
			pp11_s2 <= am_s1[63:32] * bm_s1[63:32];
			neg_s2  <= neg_s1;
			mag_s3  <= shr_c[62:0];
			neg_s3  <= neg_s2;
			p_s4    <= neg_s3 ? -$signed({1'b0, mag_s3}) : $signed({1'b0, mag_s3});
		end
	end

	assign p_o = p_s4;

endmodule

FILE: design/se3e_cdiv.sv
// Magnitude divide by a small constant: reciprocal multiply, then one correction.
// Depends on se3e_pkg for the divisor width.
module se3e_cdiv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic [63:0]                n_i,
	input  logic                       neg_i,
	input  logic [63:0]                recip_i,
	input  logic [se3e_pkg::DEN_W-1:0] den_i,
	output logic                       vld_o,
	output logic [63:0]                q_o,
	output logic                       neg_o
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [63:0] pp00_s1, pp01_s1, pp10_s1, pp11_s1, n_s1;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0] qe_s2, n_s2;
	logic [63:0] qe_s3, qd_s3, n_s3;
	logic [63:0] q_s4;
	logic [127:0] sum_c;
	logic [63:0]  rem_c;

	always_comb begin
		sum_c = {64'd0, pp00_s1} + {32'd0, pp01_s1, 32'd0} + {32'd0, pp10_s1, 32'd0}
			+ {pp11_s1, 64'd0};
		rem_c = n_s3 - qd_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= n_i[31:0] * recip_i[31:0];
			pp01_s1 <= n_i[31:0] * recip_i[63:32];
			pp10_s1 <= n_i[63:32] * recip_i[31:0];
			pp11_s1 <= n_i[63:32] * recip_i[63:32];
			n_s1    <= n_i;
			neg_s1  <= neg_i;
			qe_s2   <= sum_c[127:64];
			n_s2    <= n_s1;
			neg_s2  <= neg_s1;
			qd_s3   <= qe_s2 * 64'(den_i);
			qe_s3   <= qe_s2;
			n_s3    <= n_s2;
			neg_s3  <= neg_s2;
			q_s4    <= (rem_c >= 64'(den_i)) ? qe_s3 + 64'd1 : qe_s3;
			neg_s4  <= neg_s3;
		end
	end

	assign vld_o = vld_s4;
	assign q_o   = q_s4;
	assign neg_o = neg_s4;

endmodule

FILE: design/se3e_step.sv
// One Horner step of a trig series: s = 1 - trunc(trunc(s*x) / den).
// Depends on se3e_pkg and se3e_cdiv.
module se3e_step (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic [63:0]                smag_i,
	input  logic                       sneg_i,
	input  logic [63:0]                x_i,
	input  logic [63:0]                recip_i,
	input  logic [se3e_pkg::DEN_W-1:0] den_i,
	output logic                       vld_o,
	output logic [63:0]                smag_o,
	output logic                       sneg_o,
	output logic [63:0]                x_o
);

	logic        vld_s1, vld_s2, vld_s7;
	logic [63:0] pp00_s1, pp01_s1, pp10_s1, pp11_s1, x_s1;
	logic        neg_s1, neg_s2;
	logic [63:0] pm_s2, x_s2;
	logic [63:0] x_s3, x_s4, x_s5, x_s6, x_s7;
	logic [63:0] smag_s7;
	logic        sneg_s7;
	logic [127:0] prod_c;
	logic        vq_c, nq_c;
	logic [63:0] q_c;

	assign prod_c = {64'd0, pp00_s1} + {32'd0, pp01_s1, 32'd0} + {32'd0, pp10_s1, 32'd0}
		+ {pp11_s1, 64'd0};

	se3e_cdiv u_cdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (vld_s2),
		.n_i     (pm_s2),
		.neg_i   (neg_s2),
		.recip_i (recip_i),
		.den_i   (den_i),
		.vld_o   (vq_c),
		.q_o     (q_c),
		.neg_o   (nq_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s7 <= vq_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= smag_i[31:0] * x_i[31:0];
			pp01_s1 <= smag_i[31:0] * x_i[63:32];
			pp10_s1 <= smag_i[63:32] * x_i[31:0];
			pp11_s1 <= smag_i[63:32] * x_i[63:32];
			x_s1    <= x_i;
			neg_s1  <= sneg_i;
			pm_s2   <= {1'b0, prod_c[120:58]};
			neg_s2  <= neg_s1;
			x_s2    <= x_s1;
			x_s3    <= x_s2;
			x_s4    <= x_s3;
			x_s5    <= x_s4;
			x_s6    <= x_s5;
			x_s7    <= x_s6;
			if (nq_c) begin
				smag_s7 <= se3e_pkg::ONE + q_c;
				sneg_s7 <= 1'b0;
			end else if (q_c > se3e_pkg::ONE) begin
				smag_s7 <= q_c - se3e_pkg::ONE;
				sneg_s7 <= 1'b1;
			end else begin
				smag_s7 <= se3e_pkg::ONE - q_c;
				sneg_s7 <= 1'b0;
			end
		end
	end

	assign vld_o  = vld_s7;
	assign smag_o = smag_s7;
	assign sneg_o = sneg_s7;
	assign x_o    = x_s7;

endmodule

FILE: design/se3e_series.sv
// Three lanes of Horner steps giving a, b and c, each closed by a factorial divide.
// Depends on se3e_pkg, se3e_step and se3e_cdiv.
module se3e_series (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  logic [63:0]        x_i,
	output logic               vld_o,
	output logic signed [63:0] a_o,
	output logic signed [63:0] b_o,
	output logic signed [63:0] c_o
);

	localparam int T = se3e_pkg::SERIES_TERMS;
	localparam int L = se3e_pkg::LANES;

	logic [63:0] smag [L][T+1];
	logic        sneg [L][T+1];
	logic [63:0] xs   [L][T+1];
	logic        vs   [L][T+1];
	logic [63:0] qf   [L];
	logic        negf [L];
	logic        vf   [L];
	logic signed [63:0] coef_q [L];
	logic        vld_q;

	for (genvar l = 0; l < L; l++) begin : g_lane
		assign smag[l][0] = se3e_pkg::ONE;
		assign sneg[l][0] = 1'b0;
		assign xs[l][0]   = x_i;
		assign vs[l][0]   = vld_i;

		for (genvar j = 0; j < T; j++) begin : g_term
			localparam int NN = 2 * (T - j) + l;
			localparam logic [se3e_pkg::DEN_W-1:0] DEN = se3e_pkg::DEN_W'(NN * (NN + 1));
			localparam logic [63:0] RECIP = se3e_pkg::RECIP_NUM / 64'(DEN);

			se3e_step u_step (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.vld_i   (vs[l][j]),
				.smag_i  (smag[l][j]),
				.sneg_i  (sneg[l][j]),
				.x_i     (xs[l][j]),
				.recip_i (RECIP),
				.den_i   (DEN),
				.vld_o   (vs[l][j+1]),
				.smag_o  (smag[l][j+1]),
				.sneg_o  (sneg[l][j+1]),
				.x_o     (xs[l][j+1])
			);
		end

		localparam int FACT = (l == 2) ? 6 : l + 1;
		localparam logic [se3e_pkg::DEN_W-1:0] FDEN = se3e_pkg::DEN_W'(FACT);
		localparam logic [63:0] FRECIP = se3e_pkg::RECIP_NUM / 64'(FDEN);

		se3e_cdiv u_fact (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_i   (vs[l][T]),
			.n_i     (smag[l][T]),
			.neg_i   (sneg[l][T]),
			.recip_i (FRECIP),
			.den_i   (FDEN),
			.vld_o   (vf[l]),
			.q_o     (qf[l]),
			.neg_o   (negf[l])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				coef_q[l] <= negf[l] ? -$signed(qf[l]) : $signed(qf[l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vf[0];
		end
	end

	assign vld_o = vld_q;
	assign a_o   = coef_q[0];
	assign b_o   = coef_q[1];
	assign c_o   = coef_q[2];

endmodule

FILE: design/se3e_compose.sv
// Builds W and W^2, forms R and V*v from a, b, c, rounds and saturates.
// Depends on se3e_pkg and se3e_smul.
module se3e_compose (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_i,
	input  logic signed [63:0]     a_i,
	input  logic signed [63:0]     b_i,
	input  logic signed [63:0]     c_i,
	input  se3e_pkg::side_t        side_i,
	output logic                   vld_o,
	output se3e_pkg::pose_t        pose_o
);

	logic [14:1]        vld_s;
	logic signed [63:0] pw_s1 [3][3];
	logic signed [63:0] we_s1 [3];
	logic signed [63:0] a_s1, b_s1, c_s1, a_s2, b_s2, c_s2;
	logic [2:0][31:0]   v_s [1:7];
	logic signed [63:0] w2_s2 [3][3];
	logic signed [63:0] wm_s2 [3][3];
	logic signed [63:0] ta [3][3];
	logic signed [63:0] tb [3][3];
	logic signed [63:0] ua [3][3];
	logic signed [63:0] uc [3][3];
	logic signed [63:0] vp [3][3];
	logic signed [63:0] r_s7 [3][3];
	logic signed [63:0] vv_s7 [3][3];
	logic signed [63:0] r_s8 [3][3];
	logic signed [63:0] r_s9 [3][3];
	logic signed [63:0] r_s10 [3][3];
	logic signed [63:0] r_s11 [3][3];
	logic [63:0]        rmag_s12 [3][3];
	logic               rneg_s12 [3][3];
	logic signed [63:0] acc_s12 [3];
	logic [31:0]        rq_s13 [3][3];
	logic [63:0]        amag_s13 [3];
	logic               aneg_s13 [3];
	logic [31:0]        rq_s14 [3][3];
	logic [31:0]        move_s14 [3];
	logic [63:0]        rr_c [3][3];
	logic [63:0]        mm_c [3];

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			se3e_smul u_ta (.clk(clk), .en(en), .a_i(a_s2), .b_i(wm_s2[i][j]),
				.sh_i(7'(se3e_pkg::W_SH)), .p_o(ta[i][j]));
			se3e_smul u_tb (.clk(clk), .en(en), .a_i(b_s2), .b_i(w2_s2[i][j]),
				.sh_i(7'(se3e_pkg::W2_SH)), .p_o(tb[i][j]));
			se3e_smul u_ua (.clk(clk), .en(en), .a_i(b_s2), .b_i(wm_s2[i][j]),
				.sh_i(7'(se3e_pkg::W_SH)), .p_o(ua[i][j]));
			se3e_smul u_uc (.clk(clk), .en(en), .a_i(c_s2), .b_i(w2_s2[i][j]),
				.sh_i(7'(se3e_pkg::W2_SH)), .p_o(uc[i][j]));
			se3e_smul u_vp (.clk(clk), .en(en), .a_i(vv_s7[i][j]),
				.b_i(64'($signed(v_s[7][j]))), .sh_i(7'(se3e_pkg::VV_SH)),
				.p_o(vp[i][j]));
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rr_c[i][j] = (rmag_s12[i][j] + se3e_pkg::R_HALF) >> se3e_pkg::R_SH;
				if (rr_c[i][j] > se3e_pkg::R_LIMIT) begin
					rr_c[i][j] = se3e_pkg::R_LIMIT;
				end
			end
			mm_c[i] = (amag_s13[i] + se3e_pkg::V_HALF) >> se3e_pkg::V_SH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[13:1], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				we_s1[i] <= 64'($signed(side_i.w[i]));
				for (int j = 0; j < 3; j++) begin
					pw_s1[i][j] <= $signed(side_i.w[i]) * $signed(side_i.w[j]);
				end
			end
			a_s1 <= a_i;
			b_s1 <= b_i;
			c_s1 <= c_i;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			v_s[1] <= side_i.v;
			for (int k = 2; k <= 7; k++) begin
				v_s[k] <= v_s[k-1];
			end

			w2_s2[0][0] <= -pw_s1[1][1] - pw_s1[2][2];
			w2_s2[1][1] <= -pw_s1[2][2] - pw_s1[0][0];
			w2_s2[2][2] <= -pw_s1[0][0] - pw_s1[1][1];
			w2_s2[0][1] <= pw_s1[0][1];
			w2_s2[0][2] <= pw_s1[0][2];
			w2_s2[1][0] <= pw_s1[1][0];
			w2_s2[1][2] <= pw_s1[1][2];
			w2_s2[2][0] <= pw_s1[2][0];
			w2_s2[2][1] <= pw_s1[2][1];
			wm_s2[0][0] <= '0;
			wm_s2[0][1] <= -we_s1[2];
			wm_s2[0][2] <= we_s1[1];
			wm_s2[1][0] <= we_s1[2];
			wm_s2[1][1] <= '0;
			wm_s2[1][2] <= -we_s1[0];
			wm_s2[2][0] <= -we_s1[1];
			wm_s2[2][1] <= we_s1[0];
			wm_s2[2][2] <= '0;

			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r_s7[i][j]  <= ((i == j) ? $signed(se3e_pkg::ONE) : 64'sd0)
						+ ta[i][j] + tb[i][j];
					vv_s7[i][j] <= ((i == j) ? $signed(se3e_pkg::ONE) : 64'sd0)
						+ ua[i][j] + uc[i][j];
					r_s8[i][j]  <= r_s7[i][j];
					r_s9[i][j]  <= r_s8[i][j];
					r_s10[i][j] <= r_s9[i][j];
					r_s11[i][j] <= r_s10[i][j];
					rmag_s12[i][j] <= r_s11[i][j][63] ? 64'(-r_s11[i][j]) : 64'(r_s11[i][j]);
					rneg_s12[i][j] <= r_s11[i][j][63];
					rq_s13[i][j] <= rneg_s12[i][j] ? 32'(-rr_c[i][j]) : rr_c[i][j][31:0];
					rq_s14[i][j] <= rq_s13[i][j];
				end
				acc_s12[i]  <= vp[i][0] + vp[i][1] + vp[i][2];
				amag_s13[i] <= acc_s12[i][63] ? 64'(-acc_s12[i]) : 64'(acc_s12[i]);
				aneg_s13[i] <= acc_s12[i][63];
				if (aneg_s13[i]) begin
					move_s14[i] <= (mm_c[i] > se3e_pkg::NEG_LIMIT) ?
						se3e_pkg::NEG_LIMIT[31:0] : 32'(-mm_c[i]);
				end else begin
					move_s14[i] <= (mm_c[i] > se3e_pkg::POS_LIMIT) ?
						se3e_pkg::POS_LIMIT[31:0] : mm_c[i][31:0];
				end
			end
		end
	end

	always_comb begin
		pose_o.m_00   = rq_s14[0][0];
		pose_o.m_01   = rq_s14[0][1];
		pose_o.m_02   = rq_s14[0][2];
		pose_o.m_10   = rq_s14[1][0];
		pose_o.m_11   = rq_s14[1][1];
		pose_o.m_12   = rq_s14[1][2];
		pose_o.m_20   = rq_s14[2][0];
		pose_o.m_21   = rq_s14[2][1];
		pose_o.m_22   = rq_s14[2][2];
		pose_o.move_x = move_s14[0];
		pose_o.move_y = move_s14[1];
		pose_o.move_z = move_s14[2];
	end

	assign vld_o = vld_s[14];

endmodule

FILE: design/se3_exponential_map_top.sv
// SE(3) exponential map: twist in, rotation matrix and translation out.
// One twist per cycle sustained while the output buffer is not full.
// Throughput is set by a fully pipelined datapath under one stall enable; a two-entry
// output buffer takes the finished pose, so input is still taken while one pose waits.
// Reset clears the valid bits, the buffer count and the buffer pointers only; no clearing pass.
// Depends on se3e_pkg, se3e_series, se3e_compose.
module se3_exponential_map_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             twist_valid,
	output logic             twist_ready,
	input  se3e_pkg::twist_t twist,
	output logic             pose_valid,
	input  logic             pose_ready,
	output se3e_pkg::pose_t  pose
);

	localparam int SL = se3e_pkg::SER_LAT;

	logic               en;
	logic               vld_s1, vld_s2;
	logic [63:0]        sq0_s1, sq1_s1, sq2_s1;
	logic [63:0]        x_s2;
	se3e_pkg::side_t    side_c, side_s1, side_s2;
	se3e_pkg::side_t    side_d [1:SL];
	logic               ser_vld;
	logic signed [63:0] coef_a, coef_b, coef_c;
	logic               cmp_vld;
	se3e_pkg::pose_t    cmp_pose;
	se3e_pkg::pose_t    buf_q [2];
	logic [1:0]         cnt_q;
	logic               wr_q, rd_q;
	logic               push, pop;

	assign en          = (cnt_q != 2'd2);
	assign twist_ready = en;
	assign push        = en && cmp_vld;
	assign pop         = (cnt_q != 2'd0) && pose_ready;

	always_comb begin
		side_c.v[0] = twist.trans_x;
		side_c.v[1] = twist.trans_y;
		side_c.v[2] = twist.trans_z;
		side_c.w[0] = twist.rot_x;
		side_c.w[1] = twist.rot_y;
		side_c.w[2] = twist.rot_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= twist_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq0_s1  <= $signed(twist.rot_x) * $signed(twist.rot_x);
			sq1_s1  <= $signed(twist.rot_y) * $signed(twist.rot_y);
			sq2_s1  <= $signed(twist.rot_z) * $signed(twist.rot_z);
			side_s1 <= side_c;
			x_s2    <= sq0_s1 + sq1_s1 + sq2_s1;
			side_s2 <= side_s1;
			side_d[1] <= side_s2;
			for (int k = 2; k <= SL; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	se3e_series u_series (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s2),
		.x_i    (x_s2),
		.vld_o  (ser_vld),
		.a_o    (coef_a),
		.b_o    (coef_b),
		.c_o    (coef_c)
	);

	se3e_compose u_compose (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (ser_vld),
		.a_i    (coef_a),
		.b_i    (coef_b),
		.c_i    (coef_c),
		.side_i (side_d[SL]),
		.vld_o  (cmp_vld),
		.pose_o (cmp_pose)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= cmp_pose;
		end
	end

	assign pose_valid = (cnt_q != 2'd0);
	assign pose       = buf_q[rd_q];

endmodule
